>>> rtl/core/mcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared types and constants of the MML command stream parser: character
// codes, parse states, command and event kinds, and datapath widths.
// ----------------------------------------------------------------------------
package mcp_pkg;

	// Datapath sizing
	localparam int FULL_LENGTH = 256;
	localparam int ACC_W       = 16;
	localparam int Q_W         = $clog2(FULL_LENGTH + 1);
	localparam int LEN_W       = $clog2(2 * FULL_LENGTH);
	localparam int STEP_W      = $clog2(Q_W);
	localparam int DOT_W       = 4;
	localparam int NOTE_W      = 8;
	localparam int DUR_W       = 9;
	localparam int NUM_W       = 16;
	localparam int KIND_W      = 3;
	localparam int OCT_W       = 8;
	localparam int Q_DEPTH     = 2;
	localparam int PTR_W       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W       = $clog2(Q_DEPTH + 1);

	localparam logic [Q_W-1:0]    FULL_VEC    = Q_W'(FULL_LENGTH);
	localparam logic [LEN_W-1:0]  DEF_LEN_RST = LEN_W'(FULL_LENGTH / 4);
	localparam logic [OCT_W-1:0]  OCT_RST     = OCT_W'(4);
	localparam logic [OCT_W-1:0]  OCT_MAX     = '1;
	localparam logic [DOT_W-1:0]  DOT_MAX     = '1;
	localparam logic [NOTE_W-1:0] NOTE_TOP    = NOTE_W'(127);

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_V     = 8'h56;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// Semitone of letters A..G; the eighth entry repeats A (letter modulo 7)
	localparam logic [3:0] SEMITONE [8] = '{4'd9, 4'd11, 4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9};

	typedef enum logic [4:0] {
		ST_BEGIN,
		ST_NOTE,
		ST_NOTE_PRE,
		ST_NOTE_RUN,
		ST_REST_PRE,
		ST_REST_RUN,
		ST_OCT_PRE,
		ST_OCT_RUN,
		ST_LEN_PRE,
		ST_LEN_RUN,
		ST_VOL_PRE,
		ST_VOL_RUN,
		ST_TONE_PRE,
		ST_TONE_RUN,
		ST_TEMPO_PRE,
		ST_TEMPO_RUN
	} parse_state_t;

	typedef enum logic [1:0] {
		ACCID_NONE,
		ACCID_SHARP,
		ACCID_FLAT
	} accid_t;

	typedef enum logic [2:0] {
		CMD_NOTE,
		CMD_REST,
		CMD_OCT,
		CMD_LEN,
		CMD_VOL,
		CMD_TONE,
		CMD_TEMPO
	} cmd_kind_t;

	typedef enum logic [KIND_W-1:0] {
		EV_NOTE,
		EV_REST,
		EV_VOL,
		EV_TONE,
		EV_TEMPO
	} ev_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DOT,
		BK_EMIT
	} back_state_t;

	// One finished command handed from the front to the back
	typedef struct packed {
		cmd_kind_t         kind;
		logic [NOTE_W-1:0] note;
		logic [ACC_W-1:0]  acc;
		logic [DOT_W-1:0]  dots;
	} mcp_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/mcp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcp_front
// Character front end: folds case, runs the command parse state, keeps the
// octave, letter, accidental, number and dot registers, and pushes each
// finished command but octave changes into the command queue.
// ----------------------------------------------------------------------------
module mcp_front
	import mcp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output logic             char_stall,
	input  wire logic [7:0]  char_in,
	output logic             cmd_push,
	output mcp_cmd_t         cmd_data,
	input  wire logic        q_full
);

	parse_state_t      state_q, st_n, run_st;
	logic [OCT_W-1:0]  octave_q, oct_n;
	logic [2:0]        letter_q, letter_n;
	accid_t            accid_q, accid_n;
	logic [ACC_W-1:0]  acc_q, acc_n, acc_dig;
	logic [DOT_W-1:0]  dots_q, dots_n;

	logic [7:0]        c_up;
	logic              is_digit, is_white, dot_ok, in_pre, in_run;
	logic              fix, do_begin, accept;
	cmd_kind_t         cls;
	logic [ACC_W+3:0]  acc_prod;
	logic [NOTE_W-1:0] note_base, note_fin, oct_x12;

	assign accept     = char_valid & ~q_full;
	assign char_stall = q_full;

	// Fold case and classify the character
	always_comb begin
		c_up = char_in;
		if (char_in inside {[CH_LC_A:CH_LC_Z]}) begin
			c_up = char_in - CASE_OFS;
		end
		is_digit = c_up inside {[CH_0:CH_9]};
		is_white = c_up inside {CH_SP, CH_TAB, CH_LF, CH_CR};
		acc_prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
			+ (ACC_W+4)'(c_up - CH_0);
		acc_dig  = (acc_prod > (ACC_W+4)'({ACC_W{1'b1}})) ? '1 : acc_prod[ACC_W-1:0];
	end

	// Map the current state to its command group
	always_comb begin
		case (state_q)
			ST_NOTE, ST_NOTE_PRE, ST_NOTE_RUN: begin
				cls = CMD_NOTE; run_st = ST_NOTE_RUN; dot_ok = 1'b1;
			end
			ST_REST_PRE, ST_REST_RUN: begin
				cls = CMD_REST; run_st = ST_REST_RUN; dot_ok = 1'b1;
			end
			ST_OCT_PRE, ST_OCT_RUN: begin
				cls = CMD_OCT; run_st = ST_OCT_RUN; dot_ok = 1'b0;
			end
			ST_LEN_PRE, ST_LEN_RUN: begin
				cls = CMD_LEN; run_st = ST_LEN_RUN; dot_ok = 1'b1;
			end
			ST_VOL_PRE, ST_VOL_RUN: begin
				cls = CMD_VOL; run_st = ST_VOL_RUN; dot_ok = 1'b0;
			end
			ST_TONE_PRE, ST_TONE_RUN: begin
				cls = CMD_TONE; run_st = ST_TONE_RUN; dot_ok = 1'b0;
			end
			ST_TEMPO_PRE, ST_TEMPO_RUN: begin
				cls = CMD_TEMPO; run_st = ST_TEMPO_RUN; dot_ok = 1'b0;
			end
			default: begin
				cls = CMD_NOTE; run_st = ST_BEGIN; dot_ok = 1'b0;
			end
		endcase
		in_pre = state_q inside {ST_NOTE, ST_NOTE_PRE, ST_REST_PRE, ST_OCT_PRE,
			ST_LEN_PRE, ST_VOL_PRE, ST_TONE_PRE, ST_TEMPO_PRE};
		in_run = state_q inside {ST_NOTE_RUN, ST_REST_RUN, ST_OCT_RUN, ST_LEN_RUN,
			ST_VOL_RUN, ST_TONE_RUN, ST_TEMPO_RUN};
	end

	// Note number from the letter, octave and accidental held so far
	always_comb begin
		oct_x12   = NOTE_W'({octave_q, 3'b0}) + NOTE_W'({octave_q, 2'b0});
		note_base = NOTE_W'(SEMITONE[letter_q]) + oct_x12;
		note_fin  = note_base;
		if (accid_q == ACCID_SHARP && note_base < NOTE_TOP) begin
			note_fin = note_base + NOTE_W'(1);
		end else if (accid_q == ACCID_FLAT && note_base != '0) begin
			note_fin = note_base - NOTE_W'(1);
		end
	end

	// Next parse state: extend, finish, then reparse the character from the start
	always_comb begin
		st_n     = state_q;
		oct_n    = octave_q;
		letter_n = letter_q;
		accid_n  = accid_q;
		acc_n    = acc_q;
		dots_n   = dots_q;
		fix      = 1'b0;
		do_begin = 1'b0;
		if (in_pre) begin
			if (state_q == ST_NOTE && (c_up == CH_HASH || c_up == CH_PLUS)) begin
				accid_n = ACCID_SHARP;
				st_n    = ST_NOTE_PRE;
			end else if (state_q == ST_NOTE && c_up == CH_MINUS) begin
				accid_n = ACCID_FLAT;
				st_n    = ST_NOTE_PRE;
			end else if (is_digit) begin
				st_n  = run_st;
				acc_n = acc_dig;
			end else if (!is_white) begin
				fix = 1'b1;
			end
		end else if (in_run) begin
			if (is_digit) begin
				acc_n = acc_dig;
			end else if (dot_ok && c_up == CH_DOT) begin
				if (dots_q != DOT_MAX) begin
					dots_n = dots_q + DOT_W'(1);
				end
			end else begin
				fix = 1'b1;
			end
		end else begin
			do_begin = 1'b1;
		end

		if (fix) begin
			do_begin = 1'b1;
			st_n     = ST_BEGIN;
			if (cls == CMD_OCT) begin
				oct_n = acc_q[OCT_W-1:0];
			end
		end

		if (do_begin) begin
			if (c_up inside {[CH_A:CH_G]}) begin
				letter_n = 3'(c_up - CH_A);
				accid_n  = ACCID_NONE;
				acc_n    = '0;
				dots_n   = '0;
				st_n     = ST_NOTE;
			end else if (c_up == CH_R) begin
				acc_n  = '0;
				dots_n = '0;
				st_n   = ST_REST_PRE;
			end else if (c_up == CH_O) begin
				acc_n = '0;
				st_n  = ST_OCT_PRE;
			end else if (c_up == CH_GT) begin
				if (oct_n != OCT_MAX) begin
					oct_n = oct_n + OCT_W'(1);
				end
			end else if (c_up == CH_LT) begin
				if (oct_n != '0) begin
					oct_n = oct_n - OCT_W'(1);
				end
			end else if (c_up == CH_L) begin
				acc_n  = '0;
				dots_n = '0;
				st_n   = ST_LEN_PRE;
			end else if (c_up == CH_V) begin
				acc_n = '0;
				st_n  = ST_VOL_PRE;
			end else if (c_up == CH_AT) begin
				acc_n = '0;
				st_n  = ST_TONE_PRE;
			end else if (c_up == CH_T) begin
				acc_n = '0;
				st_n  = ST_TEMPO_PRE;
			end
		end
	end

	// Push the finished command; octave changes stay local
	always_comb begin
		cmd_push      = accept & fix & (cls != CMD_OCT);
		cmd_data.kind = cls;
		cmd_data.note = note_fin;
		cmd_data.acc  = acc_q;
		cmd_data.dots = dots_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_BEGIN;
			octave_q <= OCT_RST;
			letter_q <= '0;
			accid_q  <= ACCID_NONE;
			acc_q    <= '0;
			dots_q   <= '0;
		end else if (accept) begin
			state_q  <= st_n;
			octave_q <= oct_n;
			letter_q <= letter_n;
			accid_q  <= accid_n;
			acc_q    <= acc_n;
			dots_q   <= dots_n;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/mcp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcp_queue
// Short command queue between front and back so that each side stalls on
// its own.
// ----------------------------------------------------------------------------
module mcp_queue
	import mcp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire mcp_cmd_t  push_data,
	output logic           full,
	output logic           pop_valid,
	input  wire logic      pop_stall,
	output mcp_cmd_t       pop_data
);

	mcp_cmd_t          entry_q [Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full      = (count_q == CNT_W'(Q_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_push   = push & ~full;
	assign do_pop    = pop_valid & ~pop_stall;

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/mcp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcp_back
// Command back end: computes lengths with a bit-serial divider and a dot
// loop, keeps the default length, and drives the registered event output.
// ----------------------------------------------------------------------------
module mcp_back
	import mcp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire mcp_cmd_t          cmd_data,
	output logic                   event_valid,
	input  wire logic              event_stall,
	output logic [KIND_W-1:0]      event_kind,
	output logic [NOTE_W-1:0]      note_number,
	output logic [DUR_W-1:0]       duration,
	output logic [NUM_W-1:0]       number_value
);

	back_state_t       state_q, state_n;
	cmd_kind_t         kind_q;
	logic [NOTE_W-1:0] note_q;
	logic [ACC_W-1:0]  div_q, rem_q;
	logic [DOT_W-1:0]  dots_q;
	logic [Q_W-1:0]    dvd_q, quo_q, add_q, quo_nx;
	logic [STEP_W-1:0] step_q;
	logic [LEN_W-1:0]  len_q, def_len_q;
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [NOTE_W-1:0] out_note_q;
	logic [DUR_W-1:0]  out_dur_q;
	logic [NUM_W-1:0]  out_num_q;

	logic [ACC_W:0]    rem_sh, rem_sub;
	logic              sub_ok, emit_ok, take, dot_done, div_last, is_arg;
	ev_kind_t          ev_kind;

	assign cmd_stall    = (state_q != BK_IDLE);
	assign take         = cmd_valid & (state_q == BK_IDLE);
	assign emit_ok      = ~out_valid_q | ~event_stall;
	assign event_valid  = out_valid_q;
	assign event_kind   = out_kind_q;
	assign note_number  = out_note_q;
	assign duration     = out_dur_q;
	assign number_value = out_num_q;

	// One restoring division step per cycle
	always_comb begin
		rem_sh   = {rem_q, dvd_q[Q_W-1]};
		sub_ok   = (rem_sh >= {1'b0, div_q});
		rem_sub  = rem_sh - {1'b0, div_q};
		quo_nx   = {quo_q[Q_W-2:0], sub_ok};
		div_last = (step_q == STEP_W'(Q_W - 1));
		dot_done = (add_q == '0) || (dots_q == '0);
		is_arg   = cmd_data.kind inside {CMD_VOL, CMD_TONE, CMD_TEMPO};
	end

	// Event kind of the command in hand
	always_comb begin
		case (kind_q)
			CMD_NOTE:  ev_kind = EV_NOTE;
			CMD_REST:  ev_kind = EV_REST;
			CMD_VOL:   ev_kind = EV_VOL;
			CMD_TONE:  ev_kind = EV_TONE;
			CMD_TEMPO: ev_kind = EV_TEMPO;
			default:   ev_kind = EV_NOTE;
		endcase
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					if (is_arg) begin
						state_n = BK_EMIT;
					end else if (cmd_data.acc == '0) begin
						state_n = (cmd_data.kind == CMD_LEN) ? BK_IDLE : BK_EMIT;
					end else begin
						state_n = BK_DIV;
					end
				end
			end
			BK_DIV: begin
				if (div_last) begin
					state_n = BK_DOT;
				end
			end
			BK_DOT: begin
				if (dot_done) begin
					state_n = (kind_q == CMD_LEN) ? BK_IDLE : BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (emit_ok) begin
					state_n = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Length datapath
	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= cmd_data.kind;
			note_q <= cmd_data.note;
			div_q  <= cmd_data.acc;
			dots_q <= cmd_data.dots;
			rem_q  <= '0;
			dvd_q  <= FULL_VEC;
			quo_q  <= '0;
			step_q <= '0;
			len_q  <= def_len_q;
		end else if (state_q == BK_DIV) begin
			rem_q  <= sub_ok ? rem_sub[ACC_W-1:0] : rem_sh[ACC_W-1:0];
			dvd_q  <= dvd_q << 1;
			quo_q  <= quo_nx;
			step_q <= step_q + STEP_W'(1);
			if (div_last) begin
				len_q <= LEN_W'(quo_nx);
				add_q <= quo_nx >> 1;
			end
		end else if (state_q == BK_DOT && !dot_done) begin
			len_q  <= len_q + LEN_W'(add_q);
			add_q  <= add_q >> 1;
			dots_q <= dots_q - DOT_W'(1);
		end
	end

	// Hold the default length set by L
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_len_q <= DEF_LEN_RST;
		end else if (state_q == BK_DOT && dot_done && kind_q == CMD_LEN) begin
			def_len_q <= len_q;
		end
	end

	// Output register: load the event, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == BK_EMIT && emit_ok) begin
			out_valid_q <= 1'b1;
		end else if (!event_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_EMIT && emit_ok) begin
			out_kind_q <= ev_kind;
			if (kind_q == CMD_NOTE || kind_q == CMD_REST) begin
				out_note_q <= (kind_q == CMD_NOTE) ? note_q : '0;
				out_dur_q  <= DUR_W'(len_q);
				out_num_q  <= '0;
			end else begin
				out_note_q <= '0;
				out_dur_q  <= '0;
				out_num_q  <= div_q[NUM_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/mml_command_stream_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mml_command_stream_parser
// Music Macro Language parser: one text byte in per beat, at most one note,
// rest, volume, tone or tempo event out per byte.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+------------------------------------
//   char    | char_valid  | char_stall  | char_in
//   event   | event_valid | event_stall | event_kind, note_number,
//           |             |             | duration, number_value
//
// The front takes one byte per cycle while the two-entry command queue has
// room. For a note, rest or L command with a nonzero number the back loads
// the command, runs the bit-serial divider and then the dot loop; notes and
// rests then load the output register. Volume, tone, tempo and notes or
// rests without a number go straight to the output register; L without a
// number ends at load. Reset sets octave 4 and a quarter-note default
// length. A stalled event holds the back, then the queue, then char_stall.
// ----------------------------------------------------------------------------
module mml_command_stream_parser
	import mcp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              char_valid,
	output logic                   char_stall,
	input  wire logic [7:0]        char_in,
	output logic                   event_valid,
	input  wire logic              event_stall,
	output logic [KIND_W-1:0]      event_kind,
	output logic [NOTE_W-1:0]      note_number,
	output logic [DUR_W-1:0]       duration,
	output logic [NUM_W-1:0]       number_value
);

	logic      cmd_push, q_full, q_valid, q_stall;
	mcp_cmd_t  push_cmd, pop_cmd;

	mcp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_in    (char_in),
		.cmd_push   (cmd_push),
		.cmd_data   (push_cmd),
		.q_full     (q_full)
	);

	mcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (push_cmd),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_stall (q_stall),
		.pop_data  (pop_cmd)
	);

	mcp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd_stall    (q_stall),
		.cmd_data     (pop_cmd),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.event_kind   (event_kind),
		.note_number  (note_number),
		.duration     (duration),
		.number_value (number_value)
	);

endmodule
`default_nettype wire

>>> verif/mml_command_stream_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mml_command_stream_parser_tb
// Self-checking bench for the MML text parser. A short directed text hits
// saturation, wrap, empty arguments, whitespace and flush handling. After it
// comes a long stream of random commands with random content, mixed with
// noise bytes. A behavioral parser predicts every event. The monitor checks
// each event beat, field by field, against the oldest prediction. Both
// channels idle at random, with one calm stretch, and the sender holds twice
// until the parser has drained.
// ----------------------------------------------------------------------------
module mml_command_stream_parser_tb;
	import mcp_pkg::*;

	localparam int          IDLE_PCT    = 13;
	localparam int          HOLD_MARK   = -1;
	localparam int          RAND_BYTES  = 1850;
	localparam int          TAIL_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned ACC_LIMIT   = (1 << ACC_W) - 1;

	// Semitone of A..G within an octave
	localparam int LETTER_PITCH [7] = '{9, 11, 0, 2, 4, 5, 7};

	typedef struct packed {
		ev_kind_t          kind;
		logic [NOTE_W-1:0] note;
		logic [DUR_W-1:0]  dur;
		logic [NUM_W-1:0]  num;
	} mml_event_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              char_valid   = 1'b0;
	logic              char_stall;
	logic [7:0]        char_in      = 8'h00;
	logic              event_valid;
	logic              event_stall  = 1'b0;
	logic [KIND_W-1:0] event_kind;
	logic [NOTE_W-1:0] note_number;
	logic [DUR_W-1:0]  duration;
	logic [NUM_W-1:0]  number_value;

	// Text bytes still to send, with hold marks between them
	int         byte_q [$];
	mml_event_t want_q [$];
	mml_event_t want;

	logic        text_done   = 1'b0;
	logic        drained     = 1'b1;
	logic        calm;
	int unsigned chars_taken = 0;
	int unsigned cycle_cnt   = 0;
	int          mismatches  = 0;
	int          events_seen = 0;
	int          notes_seen  = 0;
	int          rests_seen  = 0;

	// Parser state as the predictor tracks it
	parse_state_t pstate     = ST_BEGIN;
	int unsigned  octave     = 4;
	int unsigned  dflt_len   = FULL_LENGTH / 4;
	int unsigned  cur_letter = 0;
	accid_t       accid      = ACCID_NONE;
	int unsigned  num_acc    = 0;
	int unsigned  dot_cnt    = 0;

	mml_command_stream_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_in      (char_in),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.event_kind   (event_kind),
		.note_number  (note_number),
		.duration     (duration),
		.number_value (number_value)
	);

	always #5 clk = ~clk;

	assign calm = (chars_taken >= 700) && (chars_taken < 1000);

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	// Ticks for the current number and dots; no number means the default
	function automatic int unsigned tick_length();
		int unsigned len;
		int unsigned add;
		int unsigned left;
		if (num_acc == 0)
			return dflt_len;
		len = FULL_LENGTH / num_acc;
		add = len / 2;
		left = dot_cnt;
		while (add > 0 && left > 0) begin
			len += add;
			add /= 2;
			left--;
		end
		return len;
	endfunction

	// Finish a command: update the state and queue the event it yields
	function automatic void close_command(cmd_kind_t k);
		logic [NOTE_W-1:0] pitch;
		mml_event_t        ev;
		bit                emit;
		ev.kind = EV_NOTE;
		ev.note = '0;
		ev.dur = '0;
		ev.num = '0;
		emit = 1'b1;
		case (k)
		CMD_NOTE: begin
			pitch = NOTE_W'(LETTER_PITCH[cur_letter % 7] + 12 * octave);
			if (accid == ACCID_SHARP) begin
				if (pitch < NOTE_TOP)
					pitch++;
			end else if (accid == ACCID_FLAT) begin
				if (pitch > 0)
					pitch--;
			end
			ev.note = pitch;
			ev.dur = DUR_W'(tick_length());
		end
		CMD_REST: begin
			ev.kind = EV_REST;
			ev.dur = DUR_W'(tick_length());
		end
		CMD_OCT: begin
			octave = num_acc & 255;
			emit = 1'b0;
		end
		CMD_LEN: begin
			dflt_len = tick_length();
			emit = 1'b0;
		end
		CMD_VOL: begin
			ev.kind = EV_VOL;
			ev.num = NUM_W'(num_acc);
		end
		CMD_TONE: begin
			ev.kind = EV_TONE;
			ev.num = NUM_W'(num_acc);
		end
		default: begin
			ev.kind = EV_TEMPO;
			ev.num = NUM_W'(num_acc);
		end
		endcase
		if (emit)
			want_q.push_back(ev);
		pstate = ST_BEGIN;
	endfunction

	// Before the digits: a digit opens the run, a blank is skipped, anything else closes the command
	function automatic bit arg_lead(logic [7:0] c, parse_state_t run, cmd_kind_t k);
		if (is_digit(c)) begin
			pstate = run;
			return 1'b1;
		end
		if (is_blank(c))
			return 1'b0;
		close_command(k);
		return 1'b1;
	endfunction

	// Inside the digits: accumulate with saturation, count dots if allowed, anything else closes the command
	function automatic bit arg_digits(logic [7:0] c, cmd_kind_t k, bit dots_ok);
		if (is_digit(c)) begin
			num_acc = num_acc * 10 + (c - CH_0);
			if (num_acc > ACC_LIMIT)
				num_acc = ACC_LIMIT;
			return 1'b0;
		end
		if (dots_ok && c == CH_DOT) begin
			if (dot_cnt < DOT_MAX)
				dot_cnt++;
			return 1'b0;
		end
		close_command(k);
		return 1'b1;
	endfunction

	// Predict the effect of one accepted text byte
	function automatic void parse_byte(logic [7:0] raw);
		logic [7:0] c;
		bit         again;
		int         hop;
		c = (raw >= CH_LC_A && raw <= CH_LC_Z) ? raw - CASE_OFS : raw;
		again = 1'b1;
		for (hop = 0; again && hop < 4; hop++) begin
			again = 1'b0;
			case (pstate)
			ST_BEGIN: begin
				if (c >= CH_A && c <= CH_G) begin
					cur_letter = 32'(c - CH_A);
					accid = ACCID_NONE;
					num_acc = 0;
					dot_cnt = 0;
					pstate = ST_NOTE;
				end else if (c == CH_R) begin
					num_acc = 0;
					dot_cnt = 0;
					pstate = ST_REST_PRE;
				end else if (c == CH_O) begin
					num_acc = 0;
					pstate = ST_OCT_PRE;
				end else if (c == CH_GT) begin
					if (octave < OCT_MAX)
						octave++;
				end else if (c == CH_LT) begin
					if (octave > 0)
						octave--;
				end else if (c == CH_L) begin
					num_acc = 0;
					dot_cnt = 0;
					pstate = ST_LEN_PRE;
				end else if (c == CH_V) begin
					num_acc = 0;
					pstate = ST_VOL_PRE;
				end else if (c == CH_AT) begin
					num_acc = 0;
					pstate = ST_TONE_PRE;
				end else if (c == CH_T) begin
					num_acc = 0;
					pstate = ST_TEMPO_PRE;
				end
			end
			ST_NOTE: begin
				if (c == CH_HASH || c == CH_PLUS) begin
					accid = ACCID_SHARP;
					pstate = ST_NOTE_PRE;
				end else if (c == CH_MINUS) begin
					accid = ACCID_FLAT;
					pstate = ST_NOTE_PRE;
				end else begin
					again = arg_lead(c, ST_NOTE_RUN, CMD_NOTE);
				end
			end
			ST_NOTE_PRE:  again = arg_lead(c, ST_NOTE_RUN, CMD_NOTE);
			ST_NOTE_RUN:  again = arg_digits(c, CMD_NOTE, 1'b1);
			ST_REST_PRE:  again = arg_lead(c, ST_REST_RUN, CMD_REST);
			ST_REST_RUN:  again = arg_digits(c, CMD_REST, 1'b1);
			ST_OCT_PRE:   again = arg_lead(c, ST_OCT_RUN, CMD_OCT);
			ST_OCT_RUN:   again = arg_digits(c, CMD_OCT, 1'b0);
			ST_LEN_PRE:   again = arg_lead(c, ST_LEN_RUN, CMD_LEN);
			ST_LEN_RUN:   again = arg_digits(c, CMD_LEN, 1'b1);
			ST_VOL_PRE:   again = arg_lead(c, ST_VOL_RUN, CMD_VOL);
			ST_VOL_RUN:   again = arg_digits(c, CMD_VOL, 1'b0);
			ST_TONE_PRE:  again = arg_lead(c, ST_TONE_RUN, CMD_TONE);
			ST_TONE_RUN:  again = arg_digits(c, CMD_TONE, 1'b0);
			ST_TEMPO_PRE: again = arg_lead(c, ST_TEMPO_RUN, CMD_TEMPO);
			ST_TEMPO_RUN: again = arg_digits(c, CMD_TEMPO, 1'b0);
			default:      pstate = ST_BEGIN;
			endcase
		end
	endfunction

	function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	// Stimulus text helpers
	function automatic void push_text(string s);
		foreach (s[i])
			byte_q.push_back(int'(s[i]));
	endfunction

	function automatic void push_number(int unsigned v);
		push_text($sformatf("%0d", v));
	endfunction

	function automatic void push_letter(logic [7:0] up);
		byte_q.push_back($urandom_range(1) ? up + CASE_OFS : up);
	endfunction

	function automatic void push_blank();
		case ($urandom_range(3))
		0:       byte_q.push_back(CH_SP);
		1:       byte_q.push_back(CH_TAB);
		2:       byte_q.push_back(CH_LF);
		default: byte_q.push_back(CH_CR);
		endcase
	endfunction

	// Optional blank, optional number, optional dots
	function automatic void add_argument(int unsigned usual_max, bit dotted);
		int unsigned dots;
		if ($urandom_range(4) == 0)
			push_blank();
		case ($urandom_range(19))
		0, 1: ;
		2:       push_number(0);
		3:       push_number($urandom());
		4, 5:    push_number($urandom_range(999));
		default: push_number($urandom_range(usual_max));
		endcase
		if (dotted) begin
			if ($urandom_range(9) == 0)
				dots = $urandom_range(17);
			else
				dots = $urandom_range(1) ? 0 : $urandom_range(3, 1);
			repeat (dots)
				byte_q.push_back(CH_DOT);
		end
	endfunction

	function automatic void add_random_command();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			push_letter(8'(CH_A + $urandom_range(6)));
			case ($urandom_range(5))
			0:       byte_q.push_back(CH_HASH);
			1:       byte_q.push_back(CH_PLUS);
			2:       byte_q.push_back(CH_MINUS);
			default: ;
			endcase
			add_argument(64, 1'b1);
		end else if (pick < 50) begin
			push_letter(CH_R);
			add_argument(64, 1'b1);
		end else if (pick < 58) begin
			push_letter(CH_O);
			if ($urandom_range(4) == 0)
				push_number($urandom_range(260, 245));
			else
				add_argument(10, 1'b0);
		end else if (pick < 66) begin
			repeat ($urandom_range(4, 1))
				byte_q.push_back($urandom_range(1) ? CH_GT : CH_LT);
		end else if (pick < 72) begin
			push_letter(CH_L);
			add_argument(64, 1'b1);
		end else if (pick < 78) begin
			push_letter(CH_V);
			add_argument(127, 1'b0);
		end else if (pick < 84) begin
			byte_q.push_back(CH_AT);
			add_argument(127, 1'b0);
		end else if (pick < 90) begin
			push_letter(CH_T);
			add_argument(255, 1'b0);
		end else if (pick < 96) begin
			byte_q.push_back($urandom_range(255));
		end else if (pick < 98) begin
			byte_q.push_back(CH_NUL);
		end else begin
			push_text("&");
		end
		if ($urandom_range(9) < 3)
			push_blank();
	endfunction

	// Driver: present the next byte, or idle, or hold at a hold mark
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
			char_in <= 8'h00;
		end else if (!char_valid || !char_stall) begin
			// drop a hold mark once nothing is left to deliver
			if (byte_q.size() != 0 && byte_q[0] == HOLD_MARK && !char_valid && drained)
				void'(byte_q.pop_front());
			if (byte_q.size() == 0) begin
				char_valid <= 1'b0;
				text_done <= 1'b1;
			end else if (byte_q[0] == HOLD_MARK || (!calm && $urandom_range(99) < IDLE_PCT)) begin
				char_valid <= 1'b0;
			end else begin
				char_in <= 8'(byte_q.pop_front());
				char_valid <= 1'b1;
			end
		end
	end

	// Monitor: check event beats, predict from text beats, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_stall <= 1'b0;
		end else begin
			if (event_valid && !event_stall) begin
				if (want_q.size() == 0) begin
					$error("unexpected event: kind %0d note %0d duration %0d value %0d",
						event_kind, note_number, duration, number_value);
					mismatches++;
				end else begin
					want = want_q.pop_front();
					check_field("event_kind", 16'(want.kind), 16'(event_kind));
					check_field("note_number", 16'(want.note), 16'(note_number));
					check_field("duration", 16'(want.dur), 16'(duration));
					check_field("number_value", want.num, number_value);
					events_seen++;
					if (want.kind == EV_NOTE)
						notes_seen++;
					else if (want.kind == EV_REST)
						rests_seen++;
				end
			end
			if (char_valid && !char_stall) begin
				parse_byte(char_in);
				chars_taken <= chars_taken + 1;
			end
			drained <= (want_q.size() == 0);
			event_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$error("run did not finish within %0d cycles", CYCLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		bit mid_hold;
		int opening;
		mid_hold = 1'b0;
		// Octave floor, flat at zero, dots, blank finish, volume saturation,
		// empty tone, ignored '&', empty tempo ended by a high byte, note
		// number wrap with sharp, default lengths, L set and flushed by NUL
		push_text("O0<c-8. V99999@&>T");
		byte_q.push_back(8'hFF);
		push_text("O21b+Rl3");
		byte_q.push_back(CH_NUL);
		byte_q.push_back(HOLD_MARK);
		opening = byte_q.size();
		while (byte_q.size() < opening + RAND_BYTES) begin
			add_random_command();
			if (!mid_hold && byte_q.size() > opening + RAND_BYTES / 2) begin
				byte_q.push_back(CH_NUL);
				byte_q.push_back(HOLD_MARK);
				mid_hold = 1'b1;
			end
		end
		byte_q.push_back(CH_NUL);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (!(text_done && drained))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d text bytes (directed text, random commands and noise).",
			chars_taken);
		$display("Checked %0d events: %0d notes, %0d rests, %0d volume/tone/tempo.",
			events_seen, notes_seen, rests_seen, events_seen - notes_seen - rests_seen);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
